FILE: design/jac_pkg.sv
// Shared types, constants and the microcode program of the Jacobi symbol unit.
package jac_pkg;

  localparam int unsigned JAC_DATA_WIDTH = 32;
  localparam int unsigned JAC_MOD_WIDTH  = JAC_DATA_WIDTH - 1;
  localparam int unsigned JAC_CNT_WIDTH  = $clog2(JAC_DATA_WIDTH);

  typedef struct packed {
    logic signed [JAC_DATA_WIDTH-1:0] a_value;
    logic        [JAC_MOD_WIDTH-1:0]  modulus;
  } jac_in_t;

  typedef struct packed {
    logic signed [1:0] symbol;
    logic              bad_modulus;
  } jac_out_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_MOD_INIT,
    OP_MOD_STEP,
    OP_FIX,
    OP_HALVE,
    OP_SWAP,
    OP_EMIT
  } jac_op_t;

  typedef enum logic [2:0] {
    JC_NEVER,
    JC_ALWAYS,
    JC_NO_INPUT,
    JC_BAD,
    JC_MOD_MORE,
    JC_A_ZERO,
    JC_A_EVEN,
    JC_OUT_BUSY
  } jac_cond_t;

  typedef logic [3:0] jac_step_t;

  localparam jac_step_t STEP_IDLE     = 4'd0;
  localparam jac_step_t STEP_CHECK    = 4'd1;
  localparam jac_step_t STEP_MOD_INIT = 4'd2;
  localparam jac_step_t STEP_MOD_STEP = 4'd3;
  localparam jac_step_t STEP_FIX      = 4'd4;
  localparam jac_step_t STEP_TEST     = 4'd5;
  localparam jac_step_t STEP_HALVE    = 4'd6;
  localparam jac_step_t STEP_SWAP     = 4'd7;
  localparam jac_step_t STEP_EMIT     = 4'd8;
  localparam jac_step_t STEP_RETURN   = 4'd9;

  typedef struct packed {
    jac_op_t   op;
    jac_cond_t cond;
    jac_step_t target;
  } jac_uword_t;

  // Status flags that the datapath hands to the sequencer for its jumps.
  typedef struct packed {
    logic bad;
    logic mod_more;
    logic a_zero;
    logic a_even;
  } jac_status_t;

  // The program: a jump is taken when its condition holds, else the next step runs.
  function automatic jac_uword_t jac_rom(input jac_step_t step);
    jac_uword_t w;
    begin
      case (step)
        STEP_IDLE:     w = '{op: OP_LOAD,     cond: JC_NO_INPUT, target: STEP_IDLE};
        STEP_CHECK:    w = '{op: OP_NOP,      cond: JC_BAD,      target: STEP_EMIT};
        STEP_MOD_INIT: w = '{op: OP_MOD_INIT, cond: JC_NEVER,    target: STEP_IDLE};
        STEP_MOD_STEP: w = '{op: OP_MOD_STEP, cond: JC_MOD_MORE, target: STEP_MOD_STEP};
        STEP_FIX:      w = '{op: OP_FIX,      cond: JC_NEVER,    target: STEP_IDLE};
        STEP_TEST:     w = '{op: OP_NOP,      cond: JC_A_ZERO,   target: STEP_EMIT};
        STEP_HALVE:    w = '{op: OP_HALVE,    cond: JC_A_EVEN,   target: STEP_HALVE};
        STEP_SWAP:     w = '{op: OP_SWAP,     cond: JC_ALWAYS,   target: STEP_MOD_INIT};
        STEP_EMIT:     w = '{op: OP_EMIT,     cond: JC_OUT_BUSY, target: STEP_EMIT};
        STEP_RETURN:   w = '{op: OP_NOP,      cond: JC_ALWAYS,   target: STEP_IDLE};
        default:       w = '{op: OP_NOP,      cond: JC_ALWAYS,   target: STEP_IDLE};
      endcase
      return w;
    end
  endfunction

endpackage

FILE: design/jac_seq.sv
// Microcode sequencer: step counter, program table and jump logic.
module jac_seq import jac_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        out_busy,
  input  jac_status_t status,
  output jac_op_t     op,
  output logic        at_idle
);

  jac_step_t  pc_r, pc_nxt;
  jac_uword_t uword;
  logic       taken;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  always_comb begin
    uword = jac_rom(pc_r);
    case (uword.cond)
      JC_NEVER:    taken = 1'b0;
      JC_ALWAYS:   taken = 1'b1;
      JC_NO_INPUT: taken = !in_valid;
      JC_BAD:      taken = status.bad;
      JC_MOD_MORE: taken = status.mod_more;
      JC_A_ZERO:   taken = status.a_zero;
      JC_A_EVEN:   taken = status.a_even;
      JC_OUT_BUSY: taken = out_busy;
      default:     taken = 1'b1;
    endcase
    pc_nxt  = taken ? uword.target : pc_r + 4'd1;
    op      = uword.op;
    at_idle = (pc_r == STEP_IDLE);
  end

endmodule

FILE: design/jac_dp.sv
// Datapath: operand registers, bit-serial remainder unit and sign tracking.
module jac_dp import jac_pkg::*; (
  input  logic        clk,
  input  jac_op_t     op,
  input  jac_in_t     in_data,
  output jac_status_t status,
  output jac_out_t    result
);

  localparam int unsigned W  = JAC_DATA_WIDTH;
  localparam int unsigned NW = JAC_MOD_WIDTH;
  localparam int unsigned CW = JAC_CNT_WIDTH;

  logic [W-1:0]  a_r, a_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [W-1:0]  x_r, x_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          neg_r, neg_nxt;
  logic          sgn_r, sgn_nxt;
  logic          bad_r, bad_nxt;

  logic [W-1:0]  rem_sh;
  logic [W-1:0]  n_ext;

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    n_r   <= n_nxt;
    x_r   <= x_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
    sgn_r <= sgn_nxt;
    bad_r <= bad_nxt;
  end

  always_comb begin
    a_nxt   = a_r;
    n_nxt   = n_r;
    x_nxt   = x_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    neg_nxt = neg_r;
    sgn_nxt = sgn_r;
    bad_nxt = bad_r;
    n_ext   = {1'b0, n_r};
    // The remainder stays below n, so its top bit is always clear.
    rem_sh  = {rem_r[W-2:0], x_r[W-1]};
    case (op)
      OP_LOAD: begin
        // Magnitude of the numerator; the most negative value maps to 2^(W-1).
        neg_nxt = in_data.a_value[W-1];
        a_nxt   = in_data.a_value[W-1] ? (~in_data.a_value + 1'b1) : in_data.a_value;
        n_nxt   = in_data.modulus;
        bad_nxt = ~in_data.modulus[0];
        sgn_nxt = 1'b0;
      end
      OP_MOD_INIT: begin
        x_nxt   = a_r;
        rem_nxt = '0;
        cnt_nxt = CW'(W - 1);
      end
      OP_MOD_STEP: begin
        x_nxt   = {x_r[W-2:0], 1'b0};
        rem_nxt = (rem_sh >= n_ext) ? (rem_sh - n_ext) : rem_sh;
        cnt_nxt = cnt_r - 1'b1;
      end
      OP_FIX: begin
        // A negative numerator takes the complementary residue.
        if (neg_r && (rem_r != '0)) begin
          a_nxt = {1'b0, n_r - rem_r[NW-1:0]};
        end else begin
          a_nxt = rem_r;
        end
        neg_nxt = 1'b0;
      end
      OP_HALVE: begin
        if (!a_r[0]) begin
          a_nxt = {1'b0, a_r[W-1:1]};
          if ((n_r[2:0] == 3'd3) || (n_r[2:0] == 3'd5)) begin
            sgn_nxt = ~sgn_r;
          end
        end
      end
      OP_SWAP: begin
        a_nxt = n_ext;
        n_nxt = a_r[NW-1:0];
        if ((a_r[1:0] == 2'd3) && (n_r[1:0] == 2'd3)) begin
          sgn_nxt = ~sgn_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    status.bad      = bad_r;
    status.mod_more = (cnt_r != '0);
    status.a_zero   = (a_r == '0);
    status.a_even   = ~a_r[0];
    result.bad_modulus = bad_r;
    if (!bad_r && (n_r == NW'(1))) begin
      result.symbol = sgn_r ? 2'sb11 : 2'sb01;
    end else begin
      result.symbol = 2'sb00;
    end
  end

endmodule

FILE: design/jacobi_symbol.sv
// Top level of the Jacobi symbol unit: sequencer, datapath and output register.
//
//   channel | ports                          | word
//   input   | in_valid, in_stall, in_data    | jac_in_t  (a_value, modulus)
//   output  | out_valid, out_stall, out_data | jac_out_t (symbol, bad_modulus)
//
// One word is worked on at a time. Each pass reduces the numerator modulo the modulus,
// emits at a zero residue, else halves it while even and swaps it with the modulus;
// each remainder pass runs the one-bit-per-cycle restoring remainder unit over the W
// data bits. After the result is loaded, a return step leads to idle, which takes the
// next word. A bad modulus jumps from check to emit. Reset clears the step counter and
// output valid. A waiting result sits in the output register; a new word is taken
// meanwhile and its result waits in the emit step until the register is free.
module jacobi_symbol import jac_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  jac_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output jac_out_t out_data
);

  jac_op_t     op;
  logic        at_idle;
  logic        out_busy;
  logic        emit;
  jac_status_t status;
  jac_out_t    result;

  logic        out_valid_r, out_valid_nxt;
  jac_out_t    out_data_r, out_data_nxt;

  jac_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_busy (out_busy),
    .status   (status),
    .op       (op),
    .at_idle  (at_idle)
  );

  jac_dp u_dp (
    .clk     (clk),
    .op      (op),
    .in_data (in_data),
    .status  (status),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    out_busy      = out_valid_r && out_stall;
    emit          = (op == OP_EMIT) && !out_busy;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = result;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign in_stall  = !at_idle;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: test/tb_jacobi_symbol.sv
// Self-checking testbench for the Jacobi symbol unit, with a scoreboard and random handshakes.
`timescale 1ns / 100ps

module tb_jacobi_symbol;
  import jac_pkg::*;

  localparam int IDLE_LIMIT  = 20000;
  localparam int TAIL_CYCLES = 2000;
  localparam int PHASE_WORDS = 440;

  // Scoreboard: predicts each symbol from the accepted word and checks results in order.
  class symbol_scoreboard;
    jac_out_t pending_symbols[$];
    int       mismatches;
    int       minus_count;
    int       zero_count;
    int       plus_count;
    int       bad_count;

    function new();
      mismatches  = 0;
      minus_count = 0;
      zero_count  = 0;
      plus_count  = 0;
      bad_count   = 0;
    endfunction

    function jac_out_t jacobi_of(jac_in_t w);
      longint unsigned num;
      longint unsigned den;
      longint unsigned tmp;
      int              sgn;
      jac_out_t        res;
      res = '0;
      den = w.modulus;
      if (den == 0 || den[0] == 1'b0) begin
        res.bad_modulus = 1'b1;
        return res;
      end
      // A negative numerator is reduced through its exact magnitude.
      if (w.a_value < 0) begin
        tmp = -longint'(w.a_value);
        num = tmp % den;
        if (num != 0) num = den - num;
      end else begin
        num = longint'(w.a_value) % den;
      end
      sgn = 1;
      while (num != 0) begin
        while (num[0] == 1'b0) begin
          num = num >> 1;
          if (den % 8 == 3 || den % 8 == 5) sgn = -sgn;
        end
        tmp = num;
        num = den;
        den = tmp;
        if (num % 4 == 3 && den % 4 == 3) sgn = -sgn;
        num = num % den;
      end
      if (den != 1) res.symbol = 2'b00;
      else if (sgn < 0) res.symbol = 2'b11;
      else res.symbol = 2'b01;
      return res;
    endfunction

    function void note_word(jac_in_t w);
      pending_symbols.push_back(jacobi_of(w));
    endfunction

    function void check_word(jac_out_t got);
      jac_out_t want;
      if (pending_symbols.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: symbol %0d bad_modulus %0b",
                   got.symbol, got.bad_modulus);
        return;
      end
      want = pending_symbols.pop_front();
      if (got.symbol !== want.symbol || got.bad_modulus !== want.bad_modulus) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected symbol %0d bad_modulus %0b, got symbol %0d bad_modulus %0b",
                   want.symbol, want.bad_modulus, got.symbol, got.bad_modulus);
      end
      if (want.bad_modulus) bad_count++;
      else if (want.symbol == 2'b11) minus_count++;
      else if (want.symbol == 2'b00) zero_count++;
      else plus_count++;
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  jac_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  jac_out_t out_data;

  int               sender_idle_pct = 0;
  int               receiver_stall_pct = 0;
  int               idle_cycles = 0;
  int               words_sent = 0;
  symbol_scoreboard sb = new();

  jacobi_symbol dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  // Result side: check accepted words and pick the stall for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
      sb.check_word(out_data);
    out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (rst_n && out_valid === 1'b1 && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
               idle_cycles, sb.pending_symbols.size());
      $display("tb_jacobi_symbol: errors");
      $finish;
    end
  end

  function automatic jac_in_t make_word(logic signed [31:0] a, logic [30:0] n);
    jac_in_t w;
    w.a_value = a;
    w.modulus = n;
    return w;
  endfunction

  function automatic jac_in_t draw_word();
    jac_in_t     w;
    int unsigned pick;
    int unsigned wd;
    int unsigned mask;
    int unsigned f;
    logic [30:0] m;
    logic [31:0] a;
    pick = $urandom_range(99);
    if (pick < 8) begin
      m = 31'(($urandom & 32'h7fff_ffff) >> $urandom_range(0, 30));
      m[0] = 1'b0;
      if ($urandom_range(7) == 0) m = '0;
      a = $urandom;
    end else if (pick < 18) begin
      // Shared odd factor between numerator and modulus.
      f = 2 * $urandom_range(1, 49) + 1;
      m = 31'(f * (2 * $urandom_range(0, 9999) + 1));
      a = f * $urandom_range(0, 20000000);
      if ($urandom_range(1)) a = -a;
    end else begin
      wd = $urandom_range(1) ? $urandom_range(1, 31) : $urandom_range(1, 12);
      mask = 32'hffff_ffff >> (32 - wd);
      m = 31'($urandom & mask);
      m[wd-1] = 1'b1;
      m[0] = 1'b1;
      pick = $urandom_range(99);
      if (pick < 60) a = $urandom;
      else if (pick < 80) a = $urandom_range(0, 511) - 256;
      else a = m * $urandom_range(0, 3) + $urandom_range(0, 4) - 2;
    end
    w = make_word(a, m);
    return w;
  endfunction

  task automatic send_word(jac_in_t w);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_word(w);
    words_sent++;
  endtask

  // Holds the sender off until every predicted result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_symbols.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, int count);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (count) send_word(draw_word());
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words: bad moduli, modulus one, extremes, zero and common factors.
    send_word(make_word(32'sd12345, 31'd0));
    send_word(make_word(-32'sd7, 31'd2));
    send_word(make_word(32'sh7fff_ffff, 31'h7fff_fffe));
    send_word(make_word(32'sh8000_0000, 31'd1));
    send_word(make_word(32'sh7fff_ffff, 31'd1));
    send_word(make_word(32'sd0, 31'd1));
    send_word(make_word(32'sh7fff_ffff, 31'h7fff_ffff));
    send_word(make_word(32'sh8000_0000, 31'h7fff_ffff));
    send_word(make_word(32'sd2, 31'h7fff_ffff));
    send_word(make_word(-32'sd1, 31'h7fff_ffff));
    send_word(make_word(32'sd0, 31'd15));
    send_word(make_word(32'sd105, 31'd15));
    send_word(make_word(-32'sd45, 31'd15));
    send_word(make_word(32'sd6, 31'd9));
    send_word(make_word(32'sd2, 31'd3));
    send_word(make_word(32'sd2, 31'd7));
    send_word(make_word(32'sd2, 31'd5));
    send_word(make_word(-32'sd1, 31'd3));
    send_word(make_word(-32'sd1, 31'd5));
    send_word(make_word(32'sd3, 31'd7));
    send_word(make_word(32'sd1001, 31'd9907));
    send_word(make_word(32'sh8000_0000, 31'd3));
    send_word(make_word(32'sh8000_0000, 31'h7fff_fffd));
    drain();

    run_phase(0, 0, PHASE_WORDS);
    run_phase(59, 0, PHASE_WORDS);
    run_phase(0, 59, PHASE_WORDS);
    run_phase(35, 35, PHASE_WORDS);

    while (sb.pending_symbols.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d words through four idle and stall mixes, including bad moduli,",
             words_sent);
    $display("shared factors and extremes: %0d of -1, %0d of 0, %0d of +1, %0d bad moduli.",
             sb.minus_count, sb.zero_count, sb.plus_count, sb.bad_count);
    if (sb.mismatches == 0 && sb.pending_symbols.size() == 0)
      $display("tb_jacobi_symbol: clean");
    else
      $display("tb_jacobi_symbol: errors");
    $finish;
  end

endmodule

FILE: files.f
design/jac_pkg.sv
design/jac_seq.sv
design/jac_dp.sv
design/jacobi_symbol.sv
test/tb_jacobi_symbol.sv
